// ===== hw/rtl/adm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types, microprogram and saturation helper for the admittance controller.
package adm_pkg;

  localparam int N_DOF     = 6;
  localparam int DOF_IDX_W = (N_DOF > 1) ? $clog2(N_DOF) : 1;

  localparam int NUM_W     = 49;  // signed net force term
  localparam int MAG_W     = 48;  // magnitude of the net force term
  localparam int Q_W       = 64;  // first quotient and divider shift register
  localparam int ACC_W     = 80;  // q*t plus the second quotient
  localparam int REM_W     = 31;  // divider remainder, always below the mass
  localparam int PROD_W    = 66;  // product of two signed 33-bit operands
  localparam int OPND_W    = 33;
  localparam int PBASE_W   = 34;
  localparam int CNT_W     = 6;
  localparam int UPC_W     = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MASS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd4;

  localparam logic [30:0] GAIN_ONE = 31'd65536;

  localparam logic [CNT_W-1:0] DIV1_STEPS_M1 = 6'd63;
  localparam logic [CNT_W-1:0] DIV2_STEPS_M1 = 6'd15;

  // Microprogram entry points.
  localparam logic [UPC_W-1:0] UPC_DIV1_LOOP = 5'd9;
  localparam logic [UPC_W-1:0] UPC_DIV2_LOOP = 5'd12;
  localparam logic [UPC_W-1:0] UPC_CLR       = 5'd16;
  localparam logic [UPC_W-1:0] UPC_BAD       = 5'd17;
  localparam logic [UPC_W-1:0] UPC_HOLD      = 5'd18;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_NUM_SUB,
    OP_PBASE,
    OP_P_LO,
    OP_P_HI,
    OP_DIV1_INIT,
    OP_DIV_STEP,
    OP_SAVE_Q,
    OP_DIV2_INIT,
    OP_ACC_LO,
    OP_ACC_HI,
    OP_FINISH,
    OP_OUT_CLR,
    OP_OUT_ZERO,
    OP_OUT_HOLD
  } op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DV,
    MUL_SP,
    MUL_TV,
    MUL_ALT,
    MUL_AHT,
    MUL_RT,
    MUL_QLT,
    MUL_QHT
  } mul_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_CLR,
    C_BAD,
    C_T0,
    C_CNT_NZ
  } cond_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    op_t              op;
    mul_t             mul;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  function automatic ucode_t uc(op_t op, mul_t mul, cond_t cond,
                                logic [UPC_W-1:0] target, logic last);
    ucode_t w;
    w.op     = op;
    w.mul    = mul;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // The control store. A multiply issued in one step is read from the product register by
  // the next step, but for MUL_QLT, whose product waits through the second divider loop.
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      5'd0:  w = uc(OP_LOAD,      MUL_NONE, C_CLR,    UPC_CLR,       1'b0);
      5'd1:  w = uc(OP_NOP,       MUL_NONE, C_BAD,    UPC_BAD,       1'b0);
      5'd2:  w = uc(OP_NOP,       MUL_DV,   C_T0,     UPC_HOLD,      1'b0);
      5'd3:  w = uc(OP_NUM_SUB,   MUL_SP,   C_NEVER,  '0,            1'b0);
      5'd4:  w = uc(OP_NUM_SUB,   MUL_TV,   C_NEVER,  '0,            1'b0);
      5'd5:  w = uc(OP_PBASE,     MUL_ALT,  C_NEVER,  '0,            1'b0);
      5'd6:  w = uc(OP_P_LO,      MUL_AHT,  C_NEVER,  '0,            1'b0);
      5'd7:  w = uc(OP_P_HI,      MUL_NONE, C_NEVER,  '0,            1'b0);
      5'd8:  w = uc(OP_DIV1_INIT, MUL_NONE, C_NEVER,  '0,            1'b0);
      5'd9:  w = uc(OP_DIV_STEP,  MUL_NONE, C_CNT_NZ, UPC_DIV1_LOOP, 1'b0);
      5'd10: w = uc(OP_SAVE_Q,    MUL_RT,   C_NEVER,  '0,            1'b0);
      5'd11: w = uc(OP_DIV2_INIT, MUL_QLT,  C_NEVER,  '0,            1'b0);
      5'd12: w = uc(OP_DIV_STEP,  MUL_NONE, C_CNT_NZ, UPC_DIV2_LOOP, 1'b0);
      5'd13: w = uc(OP_ACC_LO,    MUL_QHT,  C_NEVER,  '0,            1'b0);
      5'd14: w = uc(OP_ACC_HI,    MUL_NONE, C_NEVER,  '0,            1'b0);
      5'd15: w = uc(OP_FINISH,    MUL_NONE, C_NEVER,  '0,            1'b1);
      5'd16: w = uc(OP_OUT_CLR,   MUL_NONE, C_NEVER,  '0,            1'b1);
      5'd17: w = uc(OP_OUT_ZERO,  MUL_NONE, C_NEVER,  '0,            1'b1);
      5'd18: w = uc(OP_OUT_HOLD,  MUL_NONE, C_NEVER,  '0,            1'b1);
      default: w = uc(OP_OUT_ZERO, MUL_NONE, C_NEVER, '0,            1'b1);
    endcase
    return w;
  endfunction

  // Adds a sign-magnitude delta to a base value and clamps to 32 bits.
  function automatic sat_t sat_add(logic signed [PBASE_W-1:0] base, logic neg,
                                   logic [Q_W-1:0] mag);
    logic signed [41:0] ext_base;
    logic signed [41:0] ext_mag;
    logic signed [41:0] sum;
    sat_t               r;
    ext_base = $signed({{(42-PBASE_W){base[PBASE_W-1]}}, base});
    ext_mag  = $signed({2'b00, mag[39:0]});
    sum      = neg ? (ext_base - ext_mag) : (ext_base + ext_mag);
    if (|mag[Q_W-1:40]) begin
      r.sat = 1'b1;
      r.val = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!sum[41] && (|sum[40:31])) begin
      r.sat = 1'b1;
      r.val = 32'sh7fff_ffff;
    end else if (sum[41] && !(&sum[40:31])) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = $signed(sum[31:0]);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/admittance_controller_top.sv =====
`timescale 1ns / 1ps
// Top level of the admittance controller: microcoded sequencer, datapath and per-DOF state.
//
// This block runs a virtual mass-spring-damper on one degree of freedom per input word. A
// step word (func 0) reads the stored position and velocity of its DOF, forms
// num = force - target - damping*vel/2^16 - stiffness*pos/2^16 and advances the state by
// dv = dt*num/mass and dp = dt*vel/2^16 + dt*dt*num/(2^17*mass), /mass terms truncated
// toward zero, then returns the new values, clamped to 32 bits, with a flag that tells
// whether either clamp acted. A clear word (func 1) zeroes every DOF at once. A step
// word for a DOF that does not exist returns zeros and changes nothing, and a zero time
// step returns the stored values unchanged. Control comes from a 19-word microprogram
// that drives one registered 33x33 multiplier and one restoring divider that yields one
// quotient bit per cycle. A step word spends most of its time in the divider, which forms
// 64 quotient bits for dt*|num|/mass and 16 more for the remainder term of the position
// update. Results sit in an output register, so the next word is taken as soon as the
// sequencer is idle, even while the last result still waits on a stalled consumer; the
// sequencer itself waits in its final step only when a second result would have to land
// on top of one not yet taken. The DOF state is reset to zero by rst_n with no clearing
// pass. Configuration (mass, damping, stiffness, force_target, time_step) is to be
// written through the cfg port only while the block is idle; the block does not enforce
// this. A zero mass write and unknown indexes are ignored.
module admittance_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [adm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  // Input word channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [2:0]                     in_dof,
  input  logic signed [31:0]             in_force_req,
  // Result word channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_dof_out,
  output logic signed [31:0]             out_position,
  output logic signed [31:0]             out_velocity,
  output logic                           out_saturated
);

  import adm_pkg::*;

  // Configuration registers.
  logic [30:0]        mass_r;
  logic [30:0]        damping_r;
  logic [30:0]        stiffness_r;
  logic signed [31:0] target_r;
  logic [15:0]        ts_r;

  // Per-DOF state.
  logic signed [31:0] pos_store_r [N_DOF];
  logic signed [31:0] vel_store_r [N_DOF];

  // Sequencer.
  seq_state_t       state_r, state_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ucode_t           cw;
  logic             cond_true;
  logic             out_free;
  logic             exec;
  logic             in_accept;

  // Latched input word.
  logic                 func_r;
  logic [2:0]           dof_r;
  logic signed [31:0]   force_r;
  logic                 dof_ok;
  logic [DOF_IDX_W-1:0] dof_idx;

  // Datapath registers.
  logic signed [31:0]         pos_r, pos_nxt;
  logic signed [31:0]         vel_r, vel_nxt;
  logic signed [NUM_W-1:0]    num_r, num_nxt;
  logic signed [PBASE_W-1:0]  pbase_r, pbase_nxt;
  logic [Q_W-1:0]             p_r, p_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [Q_W-1:0]             quo_r, quo_nxt;
  logic [Q_W-1:0]             q_r, q_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic signed [PROD_W-1:0]   prod_r;

  // Multiplier operands.
  logic signed [OPND_W-1:0] mul_x;
  logic signed [OPND_W-1:0] mul_y;
  logic signed [PROD_W-1:0] prod_nxt;

  // Derived values.
  logic [MAG_W-1:0]   mag;
  logic               num_neg;
  logic [REM_W:0]     div_sh;
  logic [REM_W+1:0]   div_diff;
  logic               div_ge;
  logic signed [31:0] pos_rd;
  logic signed [31:0] vel_rd;
  sat_t               vel_sat;
  sat_t               pos_sat;

  // Output register.
  logic               out_valid_r;
  logic [2:0]         out_dof_r;
  logic signed [31:0] out_pos_r;
  logic signed [31:0] out_vel_r;
  logic               out_sat_r;

  // Control word and condition select.
  assign cw        = ucode_rom(upc_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign exec      = (state_r == SEQ_RUN) && (!cw.last || out_free);
  assign in_stall  = (state_r != SEQ_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign dof_ok  = (32'(dof_r) < N_DOF);
  assign dof_idx = DOF_IDX_W'(dof_r);
  assign pos_rd  = dof_ok ? pos_store_r[dof_idx] : 32'sd0;
  assign vel_rd  = dof_ok ? vel_store_r[dof_idx] : 32'sd0;

  always_comb begin
    case (cw.cond)
      C_NEVER:  cond_true = 1'b0;
      C_CLR:    cond_true = func_r;
      C_BAD:    cond_true = !dof_ok;
      C_T0:     cond_true = (ts_r == '0);
      C_CNT_NZ: cond_true = (cnt_r != '0);
      default:  cond_true = 1'b0;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_nxt = SEQ_RUN;
          upc_nxt   = '0;
        end
      end
      SEQ_RUN: begin
        if (exec) begin
          if (cw.last) begin
            state_nxt = SEQ_IDLE;
          end else if (cond_true) begin
            upc_nxt = cw.target;
          end else begin
            upc_nxt = upc_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      upc_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r      <= GAIN_ONE;
      damping_r   <= GAIN_ONE;
      stiffness_r <= GAIN_ONE;
      target_r    <= '0;
      ts_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASS: begin
          // A zero mass would make the model meaningless, so it is dropped.
          if (|cfg_data[30:0]) begin
            mass_r <= cfg_data[30:0];
          end
        end
        REG_DAMPING:      damping_r   <= cfg_data[30:0];
        REG_STIFFNESS:    stiffness_r <= cfg_data[30:0];
        REG_FORCE_TARGET: target_r    <= $signed(cfg_data);
        REG_TIME_STEP:    ts_r        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= in_func;
      dof_r   <= in_dof;
      force_r <= in_force_req;
    end
  end

  // The shared multiplier. Its result is registered and consumed by a later step.
  always_comb begin
    case (cw.mul)
      MUL_DV: begin
        mul_x = $signed({2'b00, damping_r});
        mul_y = $signed({vel_r[31], vel_r});
      end
      MUL_SP: begin
        mul_x = $signed({2'b00, stiffness_r});
        mul_y = $signed({pos_r[31], pos_r});
      end
      MUL_TV: begin
        mul_x = $signed({17'b0, ts_r});
        mul_y = $signed({vel_r[31], vel_r});
      end
      MUL_ALT: begin
        mul_x = $signed({1'b0, mag[31:0]});
        mul_y = $signed({17'b0, ts_r});
      end
      MUL_AHT: begin
        mul_x = $signed({17'b0, mag[MAG_W-1:32]});
        mul_y = $signed({17'b0, ts_r});
      end
      MUL_RT: begin
        mul_x = $signed({2'b00, rem_r});
        mul_y = $signed({17'b0, ts_r});
      end
      MUL_QLT: begin
        mul_x = $signed({1'b0, q_r[31:0]});
        mul_y = $signed({17'b0, ts_r});
      end
      MUL_QHT: begin
        mul_x = $signed({1'b0, q_r[Q_W-1:32]});
        mul_y = $signed({17'b0, ts_r});
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign prod_nxt = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (exec && (cw.mul != MUL_NONE)) begin
      prod_r <= prod_nxt;
    end
  end

  // Magnitude of the net force term and the divider's trial subtraction.
  assign num_neg  = num_r[NUM_W-1];
  assign mag      = num_neg ? MAG_W'(-num_r) : MAG_W'(num_r);
  assign div_sh   = {rem_r, quo_r[Q_W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, mass_r};
  assign div_ge   = !div_diff[REM_W+1];

  // Final updates; both use the old position and velocity.
  assign vel_sat = sat_add($signed({{(PBASE_W-32){vel_r[31]}}, vel_r}), num_neg, q_r);
  assign pos_sat = sat_add(pbase_r, num_neg, {1'b0, acc_r[ACC_W-1:17]});

  // Datapath next values, one operation per control word.
  always_comb begin
    pos_nxt   = pos_r;
    vel_nxt   = vel_r;
    num_nxt   = num_r;
    pbase_nxt = pbase_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    q_nxt     = q_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    if (exec) begin
      case (cw.op)
        OP_LOAD: begin
          pos_nxt = pos_rd;
          vel_nxt = vel_rd;
          num_nxt = $signed({{(NUM_W-32){force_r[31]}}, force_r})
                  - $signed({{(NUM_W-32){target_r[31]}}, target_r});
        end
        OP_NUM_SUB: begin
          // An arithmetic shift of the product is the floor division by 2^16.
          num_nxt = num_r - $signed(prod_r[NUM_W+15:16]);
        end
        OP_PBASE: begin
          pbase_nxt = $signed({{(PBASE_W-32){pos_r[31]}}, pos_r})
                    + $signed(prod_r[PBASE_W+15:16]);
        end
        OP_P_LO: begin
          p_nxt = {{(Q_W-48){1'b0}}, prod_r[47:0]};
        end
        OP_P_HI: begin
          p_nxt = p_r + {prod_r[31:0], 32'b0};
        end
        OP_DIV1_INIT: begin
          rem_nxt = '0;
          quo_nxt = p_r;
          cnt_nxt = DIV1_STEPS_M1;
        end
        OP_DIV_STEP: begin
          rem_nxt = div_ge ? div_diff[REM_W-1:0] : div_sh[REM_W-1:0];
          quo_nxt = {quo_r[Q_W-2:0], div_ge};
          cnt_nxt = cnt_r - 1'b1;
        end
        OP_SAVE_Q: begin
          q_nxt = quo_r;
        end
        OP_DIV2_INIT: begin
          // The remainder term r*t/mass is below 2^16, so its top bits already
          // form a partial remainder smaller than the mass.
          rem_nxt = prod_r[REM_W+15:16];
          quo_nxt = {prod_r[15:0], {(Q_W-16){1'b0}}};
          cnt_nxt = DIV2_STEPS_M1;
        end
        OP_ACC_LO: begin
          acc_nxt = {{(ACC_W-48){1'b0}}, prod_r[47:0]}
                  + {{(ACC_W-16){1'b0}}, quo_r[15:0]};
        end
        OP_ACC_HI: begin
          acc_nxt = acc_r + {prod_r[47:0], 32'b0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    vel_r   <= vel_nxt;
    num_r   <= num_nxt;
    pbase_r <= pbase_nxt;
    p_r     <= p_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    q_r     <= q_nxt;
    acc_r   <= acc_nxt;
  end

  // DOF state: written back at the end of a step word, wiped by a clear word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_DOF; i++) begin
        pos_store_r[i] <= '0;
        vel_store_r[i] <= '0;
      end
    end else if (exec) begin
      if (cw.op == OP_OUT_CLR) begin
        for (int i = 0; i < N_DOF; i++) begin
          pos_store_r[i] <= '0;
          vel_store_r[i] <= '0;
        end
      end else if (cw.op == OP_FINISH) begin
        pos_store_r[dof_idx] <= pos_sat.val;
        vel_store_r[dof_idx] <= vel_sat.val;
      end
    end
  end

  // Output register. The last step of every program loads it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec && cw.last) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && cw.last) begin
      out_dof_r <= dof_r;
      case (cw.op)
        OP_FINISH: begin
          out_pos_r <= pos_sat.val;
          out_vel_r <= vel_sat.val;
          out_sat_r <= pos_sat.sat || vel_sat.sat;
        end
        OP_OUT_HOLD: begin
          out_pos_r <= pos_r;
          out_vel_r <= vel_r;
          out_sat_r <= 1'b0;
        end
        default: begin
          out_pos_r <= '0;
          out_vel_r <= '0;
          out_sat_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dof_out   = out_dof_r;
  assign out_position  = out_pos_r;
  assign out_velocity  = out_vel_r;
  assign out_saturated = out_sat_r;

  // A new result only appears as the sequencer finishes its word.
  a_result_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == SEQ_IDLE))
    else $error("result raised while the sequencer is still running");

  // A final step that finds the output register occupied must wait in place.
  a_final_step_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == SEQ_RUN) && cw.last && out_valid_r && out_stall)
      |=> ((state_r == SEQ_RUN) && $stable(upc_r)))
    else $error("final step ran over an untaken result");

  // The divider is only reached when the time step is nonzero.
  a_divide_needs_dt: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == SEQ_RUN) && (cw.op == OP_DIV_STEP)) |-> (ts_r != '0))
    else $error("divider running under a zero time step");

endmodule
